### rtl/cedr_pkg.sv
// ----------------------------------------------------------------------------
// cedr_pkg
// shared constants, codes and types of the call edge dedup recorder
// ----------------------------------------------------------------------------
package cedr_pkg;

  // sizing
  localparam int EDGE_CAP     = 1024;
  localparam int FUNC_COUNT   = 4096;
  localparam int WORD_BITS    = 32;
  localparam int BITMAP_WORDS = (FUNC_COUNT + WORD_BITS - 1) / WORD_BITS;

  // field widths
  localparam int OP_W     = 2;
  localparam int FID_W    = 12;
  localparam int CID_W    = 12;
  localparam int EDGE_W   = CID_W + FID_W;
  localparam int LIMIT_W  = 11;
  localparam int TOTAL_W  = 11;
  localparam int TRACE_W  = 64;
  localparam int STATUS_W = 2;

  // derived widths
  localparam int CNT_W = $clog2(EDGE_CAP + 1);
  localparam int IDX_W = (EDGE_CAP > 1) ? $clog2(EDGE_CAP) : 1;
  localparam int ROW_W = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
  localparam int BIT_W = $clog2(WORD_BITS);

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1024);

  // operation codes
  localparam logic [OP_W-1:0] OP_ENTRY = 2'd0;
  localparam logic [OP_W-1:0] OP_ALLOW = 2'd1;
  localparam logic [OP_W-1:0] OP_DENY  = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_DENIED   = 2'd1,
    ST_OVERFLOW = 2'd2
  } cedr_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_COMMIT
  } cedr_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } cedr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_scan;
    logic scan_last;
    logic out_free;
  } cedr_sts_t;

endpackage

### rtl/cedr_if.sv
// ----------------------------------------------------------------------------
// cedr_if
// valid/ready channels for event beats and result beats
// ----------------------------------------------------------------------------
interface cedr_in_if import cedr_pkg::*; ;
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [FID_W-1:0] function_id;
  logic [CID_W-1:0] caller_id;
  logic             is_indirect;

  modport source (output valid, output operation, output function_id,
                  output caller_id, output is_indirect, input ready);
  modport sink   (input valid, input operation, input function_id,
                  input caller_id, input is_indirect, output ready);
endinterface

interface cedr_out_if import cedr_pkg::*; ;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                edge_added;
  logic [TOTAL_W-1:0]  edge_total;
  logic [TRACE_W-1:0]  trace_length;

  modport source (output valid, output status, output edge_added,
                  output edge_total, output trace_length, input ready);
  modport sink   (input valid, input status, input edge_added,
                  input edge_total, input trace_length, output ready);
endinterface

### rtl/cedr_ctrl.sv
// ----------------------------------------------------------------------------
// cedr_ctrl
// sequencer: accept, scan the edge store, commit the result
// ----------------------------------------------------------------------------
module cedr_ctrl import cedr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  cedr_sts_t sts,
  output cedr_cmd_t cmd
);

  cedr_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = sts.need_scan ? S_SCAN : S_COMMIT;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        // wait for room in the output register
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/cedr_dpath.sv
// ----------------------------------------------------------------------------
// cedr_dpath
// edge store, allow bitmap, counters and output register
// ----------------------------------------------------------------------------
module cedr_dpath import cedr_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [LIMIT_W-1:0]  cfg_wr_data,
  input  logic [OP_W-1:0]     in_operation,
  input  logic [FID_W-1:0]    in_function_id,
  input  logic [CID_W-1:0]    in_caller_id,
  input  logic                in_is_indirect,
  input  cedr_cmd_t           cmd,
  output cedr_sts_t           sts,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [STATUS_W-1:0] out_status,
  output logic                out_edge_added,
  output logic [TOTAL_W-1:0]  out_edge_total,
  output logic [TRACE_W-1:0]  out_trace_length
);

  logic [EDGE_W-1:0]    edge_mem [EDGE_CAP];
  logic [WORD_BITS-1:0] bm_mem   [BITMAP_WORDS];

  logic [OP_W-1:0]      op_r;
  logic [FID_W-1:0]     fid_r;
  logic [CID_W-1:0]     cid_r;
  logic                 ind_r;
  logic                 seen_r;
  logic [CNT_W-1:0]     scan_idx_r;
  logic [CNT_W-1:0]     edge_cnt_r, edge_cnt_nxt;
  logic [LIMIT_W-1:0]   limit_r;
  logic [TRACE_W-1:0]   trace_r, trace_nxt;
  logic [EDGE_W-1:0]    edge_rd_r;
  logic [WORD_BITS-1:0] bm_rd_r;
  logic                 bm_vld_r [BITMAP_WORDS];

  logic                 out_valid_r;
  logic [STATUS_W-1:0]  out_status_r;
  logic                 out_edge_added_r;
  logic [TOTAL_W-1:0]   out_edge_total_r;
  logic [TRACE_W-1:0]   out_trace_length_r;

  logic [CNT_W-1:0]     scan_next;
  logic [IDX_W-1:0]     edge_rd_addr;
  logic [ROW_W-1:0]     in_row, row;
  logic [BIT_W-1:0]     bit_sel;
  logic                 in_range;
  logic [WORD_BITS-1:0] cur_word, new_word;
  logic                 is_entry, is_edit, full, ins, ovf, allowed;
  cedr_status_t         status;

  assign scan_next    = scan_idx_r + CNT_W'(1);
  assign edge_rd_addr = cmd.load ? '0 : IDX_W'(scan_next);
  assign in_row       = ROW_W'(in_function_id >> BIT_W);
  assign row          = ROW_W'(fid_r >> BIT_W);
  assign bit_sel      = fid_r[BIT_W-1:0];
  assign in_range     = 32'(fid_r) < FUNC_COUNT;

  assign sts.need_scan = (in_operation == OP_ENTRY) && in_is_indirect && (edge_cnt_r != '0);
  assign sts.scan_last = scan_next >= edge_cnt_r;
  assign sts.out_free  = !out_valid_r || out_ready;

  always_comb begin
    is_entry = (op_r == OP_ENTRY);
    is_edit  = ((op_r == OP_ALLOW) || (op_r == OP_DENY)) && in_range;
    full     = (32'(edge_cnt_r) >= 32'(limit_r)) || (32'(edge_cnt_r) >= EDGE_CAP);
    ins      = is_entry && ind_r && !seen_r && !full;
    ovf      = is_entry && ind_r && !seen_r && full;
    // a row never written still holds its reset value of all ones
    cur_word = bm_vld_r[row] ? bm_rd_r : '1;
    allowed  = in_range && cur_word[bit_sel];
    new_word = cur_word;
    new_word[bit_sel] = (op_r == OP_ALLOW);
    priority if (ovf) begin
      status = ST_OVERFLOW;
    end else if (is_entry && !allowed) begin
      status = ST_DENIED;
    end else begin
      status = ST_OK;
    end
    edge_cnt_nxt = ins ? edge_cnt_r + CNT_W'(1) : edge_cnt_r;
    trace_nxt    = is_entry ? trace_r + TRACE_W'(1) : trace_r;
  end

  // memories
  always_ff @(posedge clk) begin
    edge_rd_r <= edge_mem[edge_rd_addr];
    if (cmd.commit && ins) begin
      edge_mem[IDX_W'(edge_cnt_r)] <= {cid_r, fid_r};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bm_rd_r <= bm_mem[in_row];
    end
    if (cmd.commit && is_edit) begin
      bm_mem[row] <= new_word;
    end
  end

  // item capture and scan
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r       <= in_operation;
      fid_r      <= in_function_id;
      cid_r      <= in_caller_id;
      ind_r      <= in_is_indirect;
      seen_r     <= 1'b0;
      scan_idx_r <= '0;
    end else if (cmd.scan) begin
      seen_r     <= seen_r || (edge_rd_r == {cid_r, fid_r});
      scan_idx_r <= scan_next;
    end
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_cnt_r <= '0;
      trace_r    <= '0;
      limit_r    <= LIMIT_RESET;
      for (int i = 0; i < BITMAP_WORDS; i++) begin
        bm_vld_r[i] <= 1'b0;
      end
    end else begin
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
      if (cmd.commit) begin
        edge_cnt_r <= edge_cnt_nxt;
        trace_r    <= trace_nxt;
        if (is_edit) begin
          bm_vld_r[row] <= 1'b1;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status_r       <= status;
      out_edge_added_r   <= ins;
      out_edge_total_r   <= TOTAL_W'(edge_cnt_nxt);
      out_trace_length_r <= trace_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_edge_added   = out_edge_added_r;
  assign out_edge_total   = out_edge_total_r;
  assign out_trace_length = out_trace_length_r;

endmodule

### rtl/call_edge_dedup_recorder_top.sv
// ----------------------------------------------------------------------------
// call_edge_dedup_recorder_top
// call edge recorder with deduplicating edge table and function allow bitmap
// ----------------------------------------------------------------------------
// Each event beat gives one result beat. A function entry advances the 64-bit
// trace length; an indirect entry looks its {caller, callee} edge up in the
// edge store and appends it when unseen and below min(edge_limit, capacity)
// (status overflow otherwise); the callee is then checked in the allow bitmap
// (status denied when its bit is clear). Allow and deny beats set or clear one
// bitmap bit. Each beat is loaded, then an indirect entry scans the stored
// edges one entry per cycle, as the edge store has one read port, and the
// result is then committed; the commit is held off for as long as the
// previous result is still unread. One beat is worked on at a time; a new beat
// is taken while the previous result still sits in the output register. The
// bitmap reset to all ones is kept by one valid bit per 32-bit row, so there
// is no clearing pass after reset. The edge limit register may be written
// only while the block is idle.
// ----------------------------------------------------------------------------
module call_edge_dedup_recorder_top import cedr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [LIMIT_W-1:0] cfg_wr_data,
  cedr_in_if.sink            in_if,
  cedr_out_if.source         out_if
);

  // command and status between sequencer and datapath
  cedr_cmd_t cmd;
  cedr_sts_t sts;
  logic      in_ready;

  assign in_if.ready = in_ready;

  // sequencer: idle / scan / commit
  cedr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // storage, counters and the result register
  cedr_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_operation     (in_if.operation),
    .in_function_id   (in_if.function_id),
    .in_caller_id     (in_if.caller_id),
    .in_is_indirect   (in_if.is_indirect),
    .cmd              (cmd),
    .sts              (sts),
    .out_ready        (out_if.ready),
    .out_valid        (out_if.valid),
    .out_status       (out_if.status),
    .out_edge_added   (out_if.edge_added),
    .out_edge_total   (out_if.edge_total),
    .out_trace_length (out_if.trace_length)
  );

endmodule

### rtl/cedr_checker.sv
// ----------------------------------------------------------------------------
// cedr_checker
// port-level checks of the recorder, bound to the top level
// ----------------------------------------------------------------------------
module cedr_checker import cedr_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] out_status,
  input logic                out_edge_added,
  input logic [TOTAL_W-1:0]  out_edge_total,
  input logic [TRACE_W-1:0]  out_trace_length
);

  logic               have_prev_r;
  logic [TOTAL_W-1:0] prev_total_r;
  logic [TRACE_W-1:0] prev_trace_r;
  logic               out_beat;

  assign out_beat = out_valid && out_ready;

  // totals of the last delivered beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r  <= 1'b0;
      prev_total_r <= '0;
      prev_trace_r <= '0;
    end else if (out_beat) begin
      have_prev_r  <= 1'b1;
      prev_total_r <= out_edge_total;
      prev_trace_r <= out_trace_length;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_edge_added)
      && $stable(out_edge_total) && $stable(out_trace_length))
    else $error("result beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_total_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_beat && have_prev_r |->
      (out_edge_total == prev_total_r) || (out_edge_total == prev_total_r + TOTAL_W'(1)))
    else $error("edge total jumped between beats");

  a_trace_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_beat && have_prev_r |->
      (out_trace_length == prev_trace_r) || (out_trace_length == prev_trace_r + TRACE_W'(1)))
    else $error("trace length jumped between beats");

  a_edge_added: assert property (@(posedge clk) disable iff (!rst_n)
    out_beat && out_edge_added |-> (out_status != ST_OVERFLOW)
      && (!have_prev_r || (out_edge_total == prev_total_r + TOTAL_W'(1))))
    else $error("added edge without table growth");

endmodule

bind call_edge_dedup_recorder_top cedr_checker u_cedr_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_if.valid),
  .out_ready        (out_if.ready),
  .out_status       (out_if.status),
  .out_edge_added   (out_if.edge_added),
  .out_edge_total   (out_if.edge_total),
  .out_trace_length (out_if.trace_length)
);
